### rtl/core/position_frame_parser_macros.svh
// Assertion macros for the position frame parser
`ifndef POSITION_FRAME_PARSER_MACROS_SVH
`define POSITION_FRAME_PARSER_MACROS_SVH

// check a consequent in the same cycle as its antecedent
`define PFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfp assertion failed");

// check a consequent in the cycle after its antecedent
`define PFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfp assertion failed");

`endif

### rtl/core/pfp_pkg.sv
// Shared constants and types for the position frame parser
package pfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int PAYLOAD_LEN = 24;
  localparam int IDX_W       = 5;

  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

  typedef struct packed {
    logic [WORD_W-1:0] z_angle_bits;
    logic [WORD_W-1:0] x_angle_bits;
    logic [WORD_W-1:0] y_angle_bits;
    logic [WORD_W-1:0] pos_x_bits;
    logic [WORD_W-1:0] pos_y_bits;
    logic [WORD_W-1:0] rate_z_bits;
  } pfp_frame_t;

endpackage

### rtl/core/pfp_ifs.sv
// Byte and frame stream interfaces of the position frame parser
interface pfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfp_frame_if;
  logic        valid;
  logic        ready;
  logic [31:0] z_angle_bits;
  logic [31:0] x_angle_bits;
  logic [31:0] y_angle_bits;
  logic [31:0] pos_x_bits;
  logic [31:0] pos_y_bits;
  logic [31:0] rate_z_bits;

  modport source (output valid, output z_angle_bits, output x_angle_bits,
                  output y_angle_bits, output pos_x_bits, output pos_y_bits,
                  output rate_z_bits, input ready);
  modport sink (input valid, input z_angle_bits, input x_angle_bits,
                input y_angle_bits, input pos_x_bits, input pos_y_bits,
                input rate_z_bits, output ready);
endinterface

### rtl/core/pfp_parser.sv
// Frame phase tracking, payload store and frame detection
`include "position_frame_parser_macros.svh"

module pfp_parser import pfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              emit,
  output pfp_frame_t        frame_words
);

  typedef enum logic [2:0] {
    P_HUNT    = 3'd0,
    P_HDR_LF  = 3'd1,
    P_PAYLOAD = 3'd2,
    P_TRL_LF  = 3'd3,
    P_TRL_CR  = 3'd4
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W-1:0]  idx_inc;
  logic              wr_en;
  logic              last_slot;
  logic [BYTE_W-1:0] store [PAYLOAD_LEN];

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    wr_en      = 1'b0;
    emit       = 1'b0;
    idx_inc    = idx + 1'b1;
    case (phase)
      P_HUNT: begin
        phase_next = (rx_byte == BYTE_CR) ? P_HDR_LF : P_HUNT;
      end
      P_HDR_LF: begin
        if (rx_byte == BYTE_LF) begin
          idx_next   = '0;
          phase_next = P_PAYLOAD;
        end else if (rx_byte != BYTE_CR) begin
          phase_next = P_HUNT;
        end
      end
      P_PAYLOAD: begin
        if (idx < IDX_W'(PAYLOAD_LEN)) begin
          wr_en    = 1'b1;
          idx_next = idx_inc;
        end
        if ((idx_next >= IDX_W'(PAYLOAD_LEN)) || (idx_next == '0)) begin
          idx_next   = '0;
          phase_next = P_TRL_LF;
        end
      end
      P_TRL_LF: begin
        phase_next = (rx_byte == BYTE_LF) ? P_TRL_CR : P_HUNT;
      end
      P_TRL_CR: begin
        phase_next = P_HUNT;
        emit       = (rx_byte == BYTE_CR);
      end
      default: begin
        phase_next = P_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_HUNT;
      idx   <= '0;
    end else if (go) begin
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && wr_en) begin
      store[idx] <= rx_byte;
    end
  end

  assign frame_words.z_angle_bits = {store[3],  store[2],  store[1],  store[0]};
  assign frame_words.x_angle_bits = {store[7],  store[6],  store[5],  store[4]};
  assign frame_words.y_angle_bits = {store[11], store[10], store[9],  store[8]};
  assign frame_words.pos_x_bits   = {store[15], store[14], store[13], store[12]};
  assign frame_words.pos_y_bits   = {store[19], store[18], store[17], store[16]};
  assign frame_words.rate_z_bits  = {store[23], store[22], store[21], store[20]};

  assign last_slot = (phase == P_PAYLOAD) && (idx == IDX_W'(PAYLOAD_LEN - 1));

  `PFP_ASSERT_NOW(a_idx_range, 1'b1, idx < IDX_W'(PAYLOAD_LEN))
  `PFP_ASSERT_NOW(a_idx_idle, phase != P_PAYLOAD, idx == '0)
  `PFP_ASSERT_NEXT(a_emit_rehunt, go && emit, phase == P_HUNT)
  `PFP_ASSERT_NEXT(a_payload_end, go && last_slot, phase == P_TRL_LF && idx == '0)

endmodule

### rtl/core/position_frame_parser.sv
// Position frame parser: CR LF framed 24-byte payload to six 32-bit words
//
// Channel rx takes one serial byte per request; channel frame returns one
// request per complete frame, carrying six little-endian 32-bit words
// (z angle, x angle, y angle, x position, y position, z rate) as raw
// single-precision bit patterns.
// A frame is 0x0D 0x0A, 24 payload bytes, then 0x0A 0x0D. Repeated 0x0D
// bytes before the header 0x0A are absorbed; any other mismatch drops back
// to the header hunt without output.
// Throughput: one byte per cycle while no completed frame waits on a held result.
// Path: the final 0x0D is taken into the input register, then the frame is
// loaded into the result register, which drives the frame request valid.
// Stalls: the result register holds a frame until it is taken; bytes keep
// flowing meanwhile, and only a byte that completes a new frame waits in
// the input register while the previous frame is still held.
// Reset: synchronous, clears the phase, the payload index and both valid
// flags; the payload store is not cleared.

`include "position_frame_parser_macros.svh"

module position_frame_parser import pfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pfp_byte_if.sink  rx,
  pfp_frame_if.source frame
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_go;
  logic              emit;
  logic              out_free;
  logic              res_valid;
  pfp_frame_t        res_frame;
  pfp_frame_t        frame_words;

  pfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .go          (s1_go),
    .rx_byte     (s1_byte),
    .emit        (emit),
    .frame_words (frame_words)
  );

  assign out_free = !res_valid || frame.ready;
  assign s1_go    = s1_valid && (!emit || out_free);
  assign rx.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rx.ready) begin
        s1_valid <= rx.valid;
      end
      if (s1_go && emit) begin
        res_valid <= 1'b1;
      end else if (frame.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
    if (s1_go && emit) begin
      res_frame <= frame_words;
    end
  end

  assign frame.valid        = res_valid;
  assign frame.z_angle_bits = res_frame.z_angle_bits;
  assign frame.x_angle_bits = res_frame.x_angle_bits;
  assign frame.y_angle_bits = res_frame.y_angle_bits;
  assign frame.pos_x_bits   = res_frame.pos_x_bits;
  assign frame.pos_y_bits   = res_frame.pos_y_bits;
  assign frame.rate_z_bits  = res_frame.rate_z_bits;

  `PFP_ASSERT_NEXT(a_emit_loads, s1_go && emit, res_valid)
  `PFP_ASSERT_NEXT(a_emit_waits, s1_valid && emit && !out_free, s1_valid && $stable(s1_byte))
  `PFP_ASSERT_NOW(a_go_has_item, s1_go, s1_valid)

endmodule
